/* rtl/core/nearest_timestamp_lookup_unit_assert.svh */
`ifndef NEAREST_TIMESTAMP_LOOKUP_UNIT_ASSERT_SVH
`define NEAREST_TIMESTAMP_LOOKUP_UNIT_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define NTL_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// implication checked at every clock edge out of reset
`define NTL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define NTL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ntl_pkg.sv */
package ntl_pkg;

	localparam int TS_W            = 64;
	localparam int INDEX_W         = 10;
	localparam int STATUS_W        = 2;
	localparam int FUNC_W          = 2;
	localparam int OUT_TDATA_W     = 80;
	localparam int DEF_TABLE_DEPTH = 1024;

	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_ORDER = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  index;
		logic [TS_W-1:0]     stamp;
	} result_t;

endpackage

/* rtl/core/nearest_timestamp_lookup_unit.sv */
// nearest timestamp lookup: a table of signed 64-bit timestamps held in one
// single-port-read synchronous memory, filled in order and searched by lower bound.
// input channel s_*: s_tuser is the function (clear, append, query), s_tdata the
// timestamp. output channel m_*: m_tuser is the status, m_tdata carries index and
// stored timestamp. every input transfer yields exactly one output transfer.
// one item is worked at a time; the next input transfer is taken once the result
// has moved into the output register, which holds it while m_tready is low.
// clear, unused function, full append and empty query finish with no memory read;
// an append into an empty table writes directly, else it first reads the last entry
// and writes only if the new timestamp is not below it (else status ORDER).
// a query runs a binary search, each probe a memory read and then a compare,
// at most ceil(log2(count + 1)) probes, then reads the neighbors and does the
// 65-bit distance compare to pick the nearer entry.
// a stalled receiver holds the result in the output register; the next result then
// holds the search engine in its done state, so s_tready stays low until m_tready returns.
// reset clears the entry count and the engine registers; memory contents are not cleared
// and are never read at or above the fill count, so there is no clearing pass.
module nearest_timestamp_lookup_unit
	import ntl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TS_W-1:0]        s_tdata,  // timestamp
	input  logic [FUNC_W-1:0]      s_tuser,  // func
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // index, entry_timestamp, zero pad
	output logic [STATUS_W-1:0]    m_tuser   // status
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [TS_W-1:0] mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	logic [TS_W-1:0] mem_rdata;
	logic            res_valid;
	logic            res_ready;
	result_t         res;
	logic            m_tvalid_q;
	result_t         out_q;

	ntl_store #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ntl_engine #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_ts     (s_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			out_q      <= '0;
		end else begin
			if (res_ready) begin
				m_tvalid_q <= res_valid;
				if (res_valid) begin
					out_q <= res;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {{(OUT_TDATA_W - INDEX_W - TS_W){1'b0}}, out_q.stamp, out_q.index};

endmodule

/* rtl/core/ntl_store.sv */
module ntl_store
	import ntl_pkg::*;
#(
	parameter int DEPTH = DEF_TABLE_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  logic [TS_W-1:0] wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output logic [TS_W-1:0] rdata
);

	logic [TS_W-1:0] mem_q [DEPTH];
	logic [TS_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/ntl_engine.sv */
`include "nearest_timestamp_lookup_unit_assert.svh"

module ntl_engine
	import ntl_pkg::*;
#(
	parameter int DEPTH = DEF_TABLE_DEPTH,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] in_func,
	input  logic [TS_W-1:0]   in_ts,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [TS_W-1:0]   mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [TS_W-1:0]   mem_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APP_RD,
		ST_SEARCH,
		ST_PROBE,
		ST_NEAR_A,
		ST_NEAR_B,
		ST_CMP,
		ST_PICK,
		ST_DONE
	} state_t;

	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   lo_q;
	logic [CW-1:0]   hi_q;
	logic [AW-1:0]   pick_q;
	logic [TS_W-1:0] ts_q;
	logic [TS_W-1:0] after_q;
	logic [TS_W:0]   d_after_q;
	logic [TS_W:0]   d_before_q;
	result_t         res_q;

	logic            in_xfer;
	logic [CW-1:0]   mid;
	logic [CW-1:0]   last;
	logic            app_first;
	logic            app_in_order;
	logic            rd_below;

	assign in_xfer      = in_valid && in_ready;
	assign in_ready     = (state_q == ST_IDLE);
	assign res_valid    = (state_q == ST_DONE);
	assign res          = res_q;
	assign mid          = lo_q + ((hi_q - lo_q) >> 1);
	assign last         = count_q - CW'(1);
	assign app_first    = (count_q == '0);
	assign rd_below     = ($signed(mem_rdata) < $signed(ts_q));
	assign app_in_order = !($signed(ts_q) < $signed(mem_rdata));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = ts_q;
		mem_re    = 1'b0;
		mem_raddr = last[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				mem_wdata = in_ts;
				if (in_valid && in_func == FUNC_APPEND) begin
					mem_we = app_first;
					mem_re = !app_first && (count_q != DEPTH_C);
				end
			end
			ST_APP_RD: begin
				mem_we = app_in_order;
			end
			ST_SEARCH: begin
				mem_re = 1'b1;
				if (lo_q < hi_q) begin
					mem_raddr = mid[AW-1:0];
				end else if (lo_q < count_q) begin
					mem_raddr = lo_q[AW-1:0];
				end
			end
			ST_NEAR_A: begin
				mem_re    = 1'b1;
				mem_raddr = pick_q - AW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			pick_q     <= '0;
			ts_q       <= '0;
			after_q    <= '0;
			d_after_q  <= '0;
			d_before_q <= '0;
			res_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						ts_q    <= in_ts;
						res_q   <= '{status: STAT_OK, index: '0, stamp: '0};
						state_q <= ST_DONE;
						priority if (in_func == FUNC_CLEAR) begin
							count_q <= '0;
						end else if (in_func == FUNC_APPEND) begin
							if (count_q == DEPTH_C) begin
								res_q.status <= STAT_FULL;
							end else if (app_first) begin
								res_q.stamp <= in_ts;
								count_q     <= CW'(1);
							end else begin
								state_q <= ST_APP_RD;
							end
						end else if (in_func == FUNC_QUERY) begin
							if (app_first) begin
								res_q.status <= STAT_EMPTY;
							end else begin
								lo_q    <= '0;
								hi_q    <= count_q;
								state_q <= ST_SEARCH;
							end
						end else begin
						end
					end
				end
				ST_APP_RD: begin
					if (app_in_order) begin
						res_q.index <= INDEX_W'(count_q);
						res_q.stamp <= ts_q;
						count_q     <= count_q + CW'(1);
					end else begin
						res_q.status <= STAT_ORDER;
					end
					state_q <= ST_DONE;
				end
				ST_SEARCH: begin
					priority if (lo_q < hi_q) begin
						state_q <= ST_PROBE;
					end else if (lo_q >= count_q) begin
						pick_q  <= last[AW-1:0];
						state_q <= ST_PICK;
					end else if (lo_q == '0) begin
						pick_q  <= '0;
						state_q <= ST_PICK;
					end else begin
						pick_q  <= lo_q[AW-1:0];
						state_q <= ST_NEAR_A;
					end
				end
				ST_PROBE: begin
					if (rd_below) begin
						lo_q <= mid + CW'(1);
					end else begin
						hi_q <= mid;
					end
					state_q <= ST_SEARCH;
				end
				ST_NEAR_A: begin
					after_q <= mem_rdata;
					state_q <= ST_NEAR_B;
				end
				ST_NEAR_B: begin
					d_after_q  <= {after_q[TS_W-1], after_q} - {ts_q[TS_W-1], ts_q};
					d_before_q <= {ts_q[TS_W-1], ts_q} - {mem_rdata[TS_W-1], mem_rdata};
					after_q    <= mem_rdata;
					state_q    <= ST_CMP;
				end
				ST_CMP: begin
					if (d_after_q < d_before_q) begin
						res_q.index <= INDEX_W'(pick_q);
						res_q.stamp <= ts_q + d_after_q[TS_W-1:0];
					end else begin
						res_q.index <= INDEX_W'(pick_q - AW'(1));
						res_q.stamp <= after_q;
					end
					state_q <= ST_DONE;
				end
				ST_PICK: begin
					res_q.index <= INDEX_W'(pick_q);
					res_q.stamp <= mem_rdata;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`NTL_ASSERT_ALWAYS(a_count_bound, count_q <= DEPTH_C, "entry count above table depth")
	`NTL_ASSERT_IMPL(a_probe_range, state_q == ST_PROBE, lo_q < hi_q && hi_q <= count_q,
		"probe outside search window")
	`NTL_ASSERT_IMPL(a_write_room, mem_we, count_q < DEPTH_C, "write into full table")
	`NTL_ASSERT_NEXT(a_one_item, in_xfer, !in_ready, "second item taken while busy")

endmodule
